FILE: rtl/rsit_pkg.sv
package rsit_pkg;

    // One slab item on the input channel
    typedef struct packed {
        logic        first_slab;
        logic        last_slab;
        logic [31:0] near_bound;
        logic [31:0] far_bound;
        logic [31:0] ray_offset;
        logic [31:0] ray_slope;
        logic [31:0] start_entry;
        logic [31:0] start_exit;
    } slab_t;

    // One result item on the output channel
    typedef struct packed {
        logic        hit;
        logic [31:0] entry_distance;
        logic [31:0] exit_distance;
        logic [2:0]  entry_slab;
    } result_t;

    // Divider widths: |diff| is 33 bits, shifted left by 16
    localparam int NUM_W  = 49;
    localparam int DEN_W  = 32;
    localparam int QUO_W  = 32;
    localparam int DSH_W  = DEN_W + QUO_W - 1;
    localparam int STEP_W = 5;

    // Saturation limits in Q16.16
    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // Divider request and response
    typedef struct packed {
        logic             go;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/rsit_div.sv
module rsit_div (
    input  logic              clk,
    input  logic              rst_n,
    input  rsit_pkg::div_req_t req,
    output rsit_pkg::div_rsp_t rsp
);
    import rsit_pkg::*;

    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quot_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              fits;

    // Restoring step: divisor slides right one bit per cycle.
    // Quotient bit 31 set means the result is at least 2^31 (saturate);
    // lower bits after that are don't-care.
    assign fits = {{(DSH_W-NUM_W){1'b0}}, rem_reg} >= dsh_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.go)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(QUO_W - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.go)
        begin
            rem_reg  <= req.num;
            dsh_reg  <= {req.den, {(QUO_W-1){1'b0}}};
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg[NUM_W-1:0];
            end
            quot_reg <= {quot_reg[QUO_W-2:0], fits};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

FILE: rtl/ray_slab_interval_test_core.sv
// Ray against slab-set interval test, signed Q16.16.
// Input channel slab (slab_valid / slab_ready): one slab per transfer.
// first_slab loads the start entry and exit distances and restarts the
// slab index; last_slab makes the block emit one result.
// Output channel result (result_valid / result_ready): hit flag, final
// entry and exit distances, and the slab that last raised the entry
// (NUM_SLABS when none did).
// Each slab needs two crossings (bound - offset) / slope, computed one
// after the other on a single shared radix-2 divider at one quotient bit
// per cycle. A zero slope skips the divider for both crossings, and a test
// already missed skips the crossings and goes straight to the update.
// slab_ready is high only while no slab is in work.
// The result sits in an output register; the next slab is taken while it
// waits. If a further last slab finishes while the previous result is
// still stalled, that slab holds in its final step until result_ready.
// Reset clears the running interval to zero, the slab index to zero,
// the best slab to NUM_SLABS and drops result_valid.
module ray_slab_interval_test_core #(
    parameter int NUM_SLABS = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             slab_valid,
    output logic             slab_ready,
    input  rsit_pkg::slab_t   slab,
    output logic             result_valid,
    input  logic             result_ready,
    output rsit_pkg::result_t result
);
    import rsit_pkg::*;

    localparam logic [2:0] SLAB_LAST = 3'(NUM_SLABS - 1);
    localparam logic [2:0] SLAB_NONE = 3'(NUM_SLABS);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_UPDATE = 2'd3;

    logic [1:0]  state_reg;
    logic        phase_reg;
    logic [31:0] entry_reg;
    logic [31:0] exit_reg;
    logic [2:0]  best_reg;
    logic [2:0]  count_reg;
    logic        missed_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    // Slab held during work
    logic [31:0] near_reg;
    logic [31:0] far_reg;
    logic [31:0] offset_reg;
    logic [31:0] slope_reg;
    logic        last_reg;
    logic [31:0] cross_reg [2];
    logic        cross_ok_reg [2];

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic        accept;
    logic        first_missed;
    logic [31:0] bound_sel;
    logic [32:0] diff;
    logic        diff_neg;
    logic        diff_zero;
    logic [32:0] diff_mag;
    logic        slope_neg;
    logic        slope_zero;
    logic [31:0] slope_mag;
    logic        quot_neg;
    logic [31:0] div_cross;
    logic [31:0] zero_cross;
    logic [31:0] cand_near;
    logic [31:0] cand_far;
    logic        ok_near;
    logic        ok_far;
    logic        raise;
    logic        lower;
    logic [31:0] upd_entry;
    logic [31:0] upd_exit;
    logic [2:0]  upd_best;
    logic        upd_miss;
    logic        can_finish;

    assign accept       = slab_valid && slab_ready;
    assign slab_ready   = (state_reg == S_IDLE);
    assign first_missed = slab.first_slab ? 1'b0 : missed_reg;

    // Difference and magnitudes for the crossing in progress
    assign bound_sel  = phase_reg ? far_reg : near_reg;
    assign diff       = {bound_sel[31], bound_sel} - {offset_reg[31], offset_reg};
    assign diff_neg   = diff[32];
    assign diff_zero  = (diff == '0);
    assign diff_mag   = diff_neg ? (33'd0 - diff) : diff;
    assign slope_neg  = slope_reg[31];
    assign slope_zero = (slope_reg == '0);
    assign slope_mag  = slope_neg ? (32'd0 - slope_reg) : slope_reg;
    assign quot_neg   = diff_neg ^ slope_neg;

    // Signed, saturated crossing from the divider quotient
    always_comb
    begin
        if (div_rsp.quot[31])
        begin
            div_cross = quot_neg ? Q_MIN : Q_MAX;
        end
        else
        begin
            div_cross = quot_neg ? (32'd0 - div_rsp.quot) : div_rsp.quot;
        end
    end

    assign zero_cross = diff_neg ? Q_MIN : Q_MAX;

    assign div_req.go  = (state_reg == S_START) && !slope_zero;
    assign div_req.num = {diff_mag, 16'd0};
    assign div_req.den = slope_mag;

    rsit_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Interval update, swapped for a negative slope
    assign cand_near = slope_neg ? cross_reg[1] : cross_reg[0];
    assign cand_far  = slope_neg ? cross_reg[0] : cross_reg[1];
    assign ok_near   = slope_neg ? cross_ok_reg[1] : cross_ok_reg[0];
    assign ok_far    = slope_neg ? cross_ok_reg[0] : cross_ok_reg[1];
    assign raise     = !missed_reg && ok_near && ($signed(cand_near) > $signed(entry_reg));
    assign lower     = !missed_reg && ok_far && ($signed(cand_far) < $signed(exit_reg));
    assign upd_entry = raise ? cand_near : entry_reg;
    assign upd_best  = raise ? count_reg : best_reg;
    assign upd_exit  = lower ? cand_far : exit_reg;
    assign upd_miss  = missed_reg || ($signed(upd_entry) > $signed(upd_exit));

    assign can_finish = !last_reg || !out_valid_reg || result_ready;

    // Sequencer and running state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= 1'b0;
            entry_reg     <= '0;
            exit_reg      <= '0;
            best_reg      <= SLAB_NONE;
            count_reg     <= '0;
            missed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (slab.first_slab)
                        begin
                            entry_reg  <= slab.start_entry;
                            exit_reg   <= slab.start_exit;
                            best_reg   <= SLAB_NONE;
                            count_reg  <= '0;
                            missed_reg <= 1'b0;
                        end
                        phase_reg <= 1'b0;
                        state_reg <= first_missed ? S_UPDATE : S_START;
                    end
                end
                S_START:
                begin
                    if (slope_zero)
                    begin
                        phase_reg <= 1'b1;
                        state_reg <= phase_reg ? S_UPDATE : S_START;
                    end
                    else
                    begin
                        state_reg <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        phase_reg <= 1'b1;
                        state_reg <= phase_reg ? S_UPDATE : S_START;
                    end
                end
                S_UPDATE:
                begin
                    if (can_finish)
                    begin
                        entry_reg  <= upd_entry;
                        exit_reg   <= upd_exit;
                        best_reg   <= upd_best;
                        missed_reg <= upd_miss;
                        if (count_reg < SLAB_LAST)
                        begin
                            count_reg <= count_reg + 3'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // Output register: loaded by a finishing last slab, freed by its transfer
            if (state_reg == S_UPDATE && can_finish && last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_valid && result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            near_reg   <= slab.near_bound;
            far_reg    <= slab.far_bound;
            offset_reg <= slab.ray_offset;
            slope_reg  <= slab.ray_slope;
            last_reg   <= slab.last_slab;
        end
        if (state_reg == S_START && slope_zero)
        begin
            cross_reg[phase_reg]    <= zero_cross;
            cross_ok_reg[phase_reg] <= !diff_zero;
        end
        if (state_reg == S_WAIT && div_rsp.done)
        begin
            cross_reg[phase_reg]    <= div_cross;
            cross_ok_reg[phase_reg] <= 1'b1;
        end
        if (state_reg == S_UPDATE && can_finish && last_reg)
        begin
            out_reg.hit            <= !upd_miss;
            out_reg.entry_distance <= upd_entry;
            out_reg.exit_distance  <= upd_exit;
            out_reg.entry_slab     <= upd_best;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: rtl/rsit_chk.sv
module rsit_chk #(
    parameter int NUM_SLABS = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             slab_valid,
    input  logic             slab_ready,
    input  rsit_pkg::slab_t   slab,
    input  logic             result_valid,
    input  logic             result_ready,
    input  rsit_pkg::result_t result
);
    import rsit_pkg::*;

    localparam logic [2:0] SLAB_NONE = 3'(NUM_SLABS);

    // Stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    // Stalled result keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

    // A slab transfer keeps the block busy for the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        slab_valid && slab_ready |=> !slab_ready && !$rose(result_valid))
        else $error("block free or result issued right after slab transfer");

    // A hit reports a non-empty interval
    a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.hit |->
            $signed(result.entry_distance) <= $signed(result.exit_distance))
        else $error("hit with entry beyond exit");

    // Entry slab index stays within range
    a_slab_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.entry_slab <= SLAB_NONE)
        else $error("entry slab out of range");

endmodule

bind ray_slab_interval_test_core rsit_chk #(.NUM_SLABS(NUM_SLABS)) u_rsit_chk (.*);
